### src/scs_pkg.sv
// Package of types, codes and constants for the segmented capture store.
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

  localparam int STORE_BYTES_DEF  = 65536;
  localparam int MAX_SEGMENTS_DEF = 256;

  localparam int WIDE_W  = 128;
  localparam int IN_DW   = 72;
  localparam int IN_UW   = 3;
  localparam int OUT_DW  = 160;
  localparam int OUT_UW  = 1;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [2:0] CMD_DATA    = 3'd0;
  localparam logic [2:0] CMD_OVERRUN = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  localparam logic [2:0] REG_SEG_BYTES  = 3'd0;
  localparam logic [2:0] REG_SEG_COUNT  = 3'd1;
  localparam logic [2:0] REG_POS_MODE   = 3'd2;
  localparam logic [2:0] REG_SAMPLE_W   = 3'd3;
  localparam logic [2:0] REG_START_US   = 3'd4;
  localparam logic [2:0] REG_RATE_NUM   = 3'd5;
  localparam logic [2:0] REG_RATE_DEN   = 3'd6;

  localparam logic [16:0] SEG_BYTES_RST = 17'd4096;
  localparam logic [8:0]  SEG_COUNT_RST = 9'd16;
  localparam logic [4:0]  SAMPLE_W_RST  = 5'd1;
  localparam logic [31:0] RATE_NUM_RST  = 32'd1000000;
  localparam logic [31:0] RATE_DEN_RST  = 32'd1;
  localparam logic [31:0] US_PER_S      = 32'd1000000;

  typedef enum logic [2:0] {
    K_DATA, K_OVERRUN, K_RELEASE, K_STOP, K_READ, K_NOP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] lost;
    logic [31:0] serial;
    logic [15:0] offset;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qv_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SLOT_GO, S_SLOT_WAIT, S_OPEN,
    S_TW_GO, S_TW_WAIT, S_TD_GO, S_TD_WAIT, S_TU_GO, S_TU_WAIT,
    S_TN_GO, S_TN_WAIT, S_ADDR, S_WRITE, S_CLOSE_GO, S_CLOSE_WAIT,
    S_READ, S_READ_WAIT, S_RESP
  } st_e;

endpackage
`default_nettype wire

### src/segmented_capture_store_top.sv
// Top level of the segmented capture store: input queue, sequencer, checks.
//
// Input stream: one item per command (tuser = cmd), tdata carries the byte,
// lost-byte count, release serial and read offset. Output stream: one result
// per item, in order; tuser flags a closed segment, tdata the segment record
// and status. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user writes them only while the block is idle; the block does not enforce it.
// Items run one at a time through the sequencer. The first byte of a segment
// also runs the start-time computation (two 128-step divisions and two
// 32-step multiplications in the shared units); an item that closes a
// segment also runs the sample-count division; the first byte after a
// segment closes also runs a division for the slot remainder.
// A two-entry input queue keeps accepting while not full as the sequencer
// works, and the output register holds a result while the receiver stalls;
// the sequencer waits only when a new result meets a full output register.
// Reset clears all counters and flags and restores register defaults; the
// byte store is not cleared. STORE_BYTES must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
module segmented_capture_store_top #(
  parameter int STORE_BYTES  = scs_pkg::STORE_BYTES_DEF,
  parameter int MAX_SEGMENTS = scs_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [scs_pkg::CFG_IW-1:0] cfg_idx_i,
  input  wire logic [scs_pkg::CFG_DW-1:0] cfg_data_i,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // data_byte[7:0], lost_bytes[23:8], release_serial[55:24], read_offset[71:56]
  input  wire logic [scs_pkg::IN_DW-1:0]  s_axis_tdata_i,
  // cmd[2:0]
  input  wire logic [scs_pkg::IN_UW-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // seg_serial[31:0], seg_position[63:32], seg_samples[83:64],
  // seg_start_us[115:84], seg_flags[117:116], paused_now[118],
  // read_data[126:119], dropped_total[158:127], overrun_seen[159]
  output logic [scs_pkg::OUT_DW-1:0]      m_axis_tdata_o,
  // segment_done[0]
  output logic [scs_pkg::OUT_UW-1:0]      m_axis_tuser_o
);
  import scs_pkg::*;

  qv_t  q;
  logic pop;

  scs_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_axis_tvalid_i), .s_axis_tready(s_axis_tready_o),
    .s_axis_tdata(s_axis_tdata_i), .s_axis_tuser(s_axis_tuser_i),
    .q_o(q), .pop_i(pop)
  );

  scs_back #(.STORE_BYTES(STORE_BYTES), .MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_i(q), .pop_o(pop),
    .m_axis_tvalid(m_axis_tvalid_o), .m_axis_tready(m_axis_tready_i),
    .m_axis_tdata(m_axis_tdata_o), .m_axis_tuser(m_axis_tuser_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q.valid)
    else $error("queue popped while empty");

  a_seg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[117:0] == '0))
    else $error("segment fields set without a closed segment");

endmodule
`default_nettype wire

### src/scs_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### src/scs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module scs_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [scs_pkg::WIDE_W-1:0] num_i,
  input  wire logic [31:0]               den_i,
  output logic                           done_o,
  output logic [scs_pkg::WIDE_W-1:0]     quo_o,
  output logic [31:0]                    rem_o
);
  import scs_pkg::*;
  localparam int CNTW = $clog2(WIDE_W);

  logic [WIDE_W-1:0] q_q;
  logic [31:0]       r_q, den_q;
  logic [CNTW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [32:0]       rsh, sub;
  logic              ge;

  assign rsh = {r_q, q_q[WIDE_W-1]};
  assign ge  = rsh >= {1'b0, den_q};
  assign sub = rsh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(WIDE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q <= {q_q[WIDE_W-2:0], ge};
      r_q <= ge ? sub[31:0] : rsh[31:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;
endmodule
`default_nettype wire

### src/scs_mul.sv
// Shift-add multiplier of a wide word by a 32-bit factor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module scs_mul (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [scs_pkg::WIDE_W-1:0] a_i,
  input  wire logic [31:0]               b_i,
  output logic                           done_o,
  output logic [scs_pkg::WIDE_W-1:0]     prod_o
);
  import scs_pkg::*;

  logic [WIDE_W-1:0] a_q, acc_q;
  logic [31:0]       b_q;
  logic [4:0]        cnt_q;
  logic              busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[WIDE_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[31:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

### src/scs_front.sv
// Input side: accepts items, classifies the command and queues them.
`timescale 1ns / 1ps
`default_nettype none
module scs_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [scs_pkg::IN_DW-1:0] s_axis_tdata,
  input  wire logic [scs_pkg::IN_UW-1:0] s_axis_tuser,
  output scs_pkg::qv_t                  q_o,
  input  wire logic                     pop_i
);
  import scs_pkg::*;

  item_t      ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      in_item;

  function automatic kind_e classify(input logic [2:0] cmd);
    kind_e k;
    case (cmd)
      CMD_DATA:    k = K_DATA;
      CMD_OVERRUN: k = K_OVERRUN;
      CMD_RELEASE: k = K_RELEASE;
      CMD_STOP:    k = K_STOP;
      CMD_READ:    k = K_READ;
      default:     k = K_NOP;
    endcase
    return k;
  endfunction

  always_comb begin
    in_item.kind   = classify(s_axis_tuser);
    in_item.data   = s_axis_tdata[7:0];
    in_item.lost   = s_axis_tdata[23:8];
    in_item.serial = s_axis_tdata[55:24];
    in_item.offset = s_axis_tdata[71:56];
  end

  assign s_axis_tready = cnt_q != 2'd2;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= in_item;
    end
  end

  assign q_o.valid = cnt_q != 2'd0;
  assign q_o.item  = ent_q[rp_q];
endmodule
`default_nettype wire

### src/scs_back.sv
// Execution side: sequencer that files bytes into segments and forms results.
`timescale 1ns / 1ps
`default_nettype none
module scs_back #(
  parameter int STORE_BYTES  = scs_pkg::STORE_BYTES_DEF,
  parameter int MAX_SEGMENTS = scs_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [scs_pkg::CFG_IW-1:0] cfg_idx_i,
  input  wire logic [scs_pkg::CFG_DW-1:0] cfg_data_i,
  input  wire scs_pkg::qv_t               q_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [scs_pkg::OUT_DW-1:0]      m_axis_tdata,
  output logic [scs_pkg::OUT_UW-1:0]      m_axis_tuser
);
  import scs_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int SLW = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int XW  = AW + SLW + 17;

  // configuration
  logic [16:0] seg_bytes_q;
  logic [8:0]  seg_count_q;
  logic        pos_mode_q;
  logic [4:0]  sample_w_q;
  logic [31:0] t0_us_q, rate_num_q, rate_den_q;

  // segment state
  logic [16:0]   fill_q, close_bytes_q;
  logic [31:0]   completed_q, released_q, dropped_q;
  logic [63:0]   captured_q;
  logic          overrun_q, gap_q, paused_q, slot_ok_q;
  logic [31:0]   open_pos_q, open_start_q;
  logic [1:0]    open_flags_q, close_flags_q;
  logic [SLW-1:0] slot_q;
  logic [AW-1:0] base_q;
  item_t         it_q;

  // result fields
  logic        r_done_q;
  logic [31:0] r_serial_q, r_pos_q, r_start_q;
  logic [19:0] r_samples_q;
  logic [1:0]  r_flags_q;
  logic [7:0]  r_read_q;

  logic                  ov_q;
  logic [OUT_DW-1:0]     od_q;
  logic [OUT_UW-1:0]     ou_q;

  st_e state_q, state_d;

  // derived values
  logic [16:0]   sb_eff;
  logic [4:0]    w_eff;
  logic [31:0]   num_eff;
  logic [CW-1:0] count_eff;
  logic          ring_full;
  logic [16:0]   fill_inc;
  logic [XW-1:0] base_prod;

  assign sb_eff    = (seg_bytes_q == '0) ? 17'd1 : seg_bytes_q;
  assign w_eff     = (sample_w_q == '0) ? 5'd1 : sample_w_q;
  assign num_eff   = (rate_num_q == '0) ? 32'd1 : rate_num_q;
  assign count_eff = (32'(seg_count_q) > 32'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                           : CW'(seg_count_q);
  assign ring_full = (completed_q - released_q) >= 32'(count_eff);
  assign fill_inc  = fill_q + 17'd1;
  assign base_prod = XW'(slot_q) * XW'(sb_eff);

  // shared units
  logic              div_start, div_done, mul_start, mul_done;
  logic [WIDE_W-1:0] div_num, div_q, mul_a, mul_p;
  logic [31:0]       div_den, div_r, mul_b;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;
  logic              out_load;

  scs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_q), .rem_o(div_r)
  );

  scs_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p)
  );

  scs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(it_q.data),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (q_i.valid) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (it_q.kind)
          K_DATA: begin
            if (ring_full)          state_d = S_RESP;
            else if (!slot_ok_q)    state_d = S_SLOT_GO;
            else if (fill_q == '0)  state_d = S_OPEN;
            else                    state_d = S_ADDR;
          end
          K_OVERRUN: state_d = (fill_q != '0) ? S_CLOSE_GO : S_RESP;
          K_STOP:    state_d = (fill_q != '0 && !ring_full) ? S_CLOSE_GO : S_RESP;
          K_READ:    state_d = S_READ;
          default:   state_d = S_RESP;
        endcase
      end
      S_SLOT_GO:    state_d = S_SLOT_WAIT;
      S_SLOT_WAIT:  if (div_done) state_d = (fill_q == '0) ? S_OPEN : S_ADDR;
      S_OPEN:       state_d = S_TW_GO;
      S_TW_GO:      state_d = S_TW_WAIT;
      S_TW_WAIT:    if (div_done) state_d = S_TD_GO;
      S_TD_GO:      state_d = S_TD_WAIT;
      S_TD_WAIT:    if (mul_done) state_d = S_TU_GO;
      S_TU_GO:      state_d = S_TU_WAIT;
      S_TU_WAIT:    if (mul_done) state_d = S_TN_GO;
      S_TN_GO:      state_d = S_TN_WAIT;
      S_TN_WAIT:    if (div_done) state_d = S_ADDR;
      S_ADDR:       state_d = S_WRITE;
      S_WRITE:      state_d = (fill_inc >= sb_eff) ? S_CLOSE_GO : S_RESP;
      S_CLOSE_GO:   state_d = S_CLOSE_WAIT;
      S_CLOSE_WAIT: if (div_done) state_d = S_RESP;
      S_READ:       state_d = S_READ_WAIT;
      S_READ_WAIT:  state_d = S_RESP;
      S_RESP:       if (!ov_q || m_axis_tready) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // control strobes and unit operands
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    div_num   = '0;
    div_den   = 32'd1;
    mul_a     = div_q;
    mul_b     = rate_den_q;
    ram_waddr = base_q + AW'(fill_q);
    ram_raddr = AW'(it_q.offset);
    case (state_q)
      S_IDLE:     pop_o = q_i.valid;
      S_SLOT_GO: begin
        div_start = 1'b1;
        div_num   = WIDE_W'(completed_q);
        div_den   = 32'(count_eff);
      end
      S_TW_GO: begin
        div_start = 1'b1;
        div_num   = WIDE_W'({captured_q, 3'b000});
        div_den   = 32'(w_eff);
      end
      S_TD_GO: mul_start = 1'b1;
      S_TU_GO: begin
        mul_start = 1'b1;
        mul_a     = mul_p;
        mul_b     = US_PER_S;
      end
      S_TN_GO: begin
        div_start = 1'b1;
        div_num   = mul_p;
        div_den   = num_eff;
      end
      S_WRITE:    ram_we = 1'b1;
      S_CLOSE_GO: begin
        div_start = 1'b1;
        div_num   = WIDE_W'({close_bytes_q, 3'b000});
        div_den   = 32'(w_eff);
      end
      S_RESP:     out_load = !ov_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_bytes_q  <= SEG_BYTES_RST;
      seg_count_q  <= SEG_COUNT_RST;
      pos_mode_q   <= 1'b0;
      sample_w_q   <= SAMPLE_W_RST;
      t0_us_q      <= '0;
      rate_num_q   <= RATE_NUM_RST;
      rate_den_q   <= RATE_DEN_RST;
      fill_q       <= '0;
      completed_q  <= '0;
      released_q   <= '0;
      captured_q   <= '0;
      dropped_q    <= '0;
      overrun_q    <= 1'b0;
      gap_q        <= 1'b0;
      paused_q     <= 1'b0;
      slot_ok_q    <= 1'b0;
      open_pos_q   <= '0;
      open_start_q <= '0;
      open_flags_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEG_BYTES: seg_bytes_q <= cfg_data_i[16:0];
          REG_SEG_COUNT: seg_count_q <= cfg_data_i[8:0];
          REG_POS_MODE:  pos_mode_q  <= cfg_data_i[0];
          REG_SAMPLE_W:  sample_w_q  <= cfg_data_i[4:0];
          REG_START_US:  t0_us_q     <= cfg_data_i;
          REG_RATE_NUM:  rate_num_q  <= cfg_data_i;
          REG_RATE_DEN:  rate_den_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_DISPATCH: begin
          case (it_q.kind)
            K_DATA: begin
              if (ring_full) begin
                dropped_q  <= dropped_q + 32'd1;
                captured_q <= captured_q + 64'd1;
                paused_q   <= 1'b1;
                if (fill_q == '0) gap_q <= 1'b1;
              end else if (paused_q && fill_q == '0) begin
                paused_q <= 1'b0;
              end
            end
            K_OVERRUN: begin
              dropped_q  <= dropped_q + 32'(it_q.lost);
              captured_q <= captured_q + 64'(it_q.lost);
              overrun_q  <= 1'b1;
              gap_q      <= 1'b1;
            end
            K_RELEASE: begin
              if ((it_q.serial + 32'd1) > released_q && it_q.serial < completed_q) begin
                released_q <= it_q.serial + 32'd1;
              end
            end
            default: ;
          endcase
        end
        S_SLOT_WAIT: if (div_done) slot_ok_q <= 1'b1;
        S_OPEN: begin
          open_pos_q   <= pos_mode_q ? captured_q[31:0]
                                     : completed_q * 32'(sb_eff);
          open_flags_q <= {1'b0, gap_q};
          gap_q        <= 1'b0;
        end
        S_TN_WAIT: if (div_done) open_start_q <= t0_us_q + div_q[31:0];
        S_WRITE: begin
          fill_q     <= fill_inc;
          captured_q <= captured_q + 64'd1;
        end
        S_CLOSE_WAIT: begin
          if (div_done) begin
            open_flags_q <= close_flags_q;
            fill_q       <= '0;
            completed_q  <= completed_q + 32'd1;
            slot_ok_q    <= 1'b0;
          end
        end
        default: ;
      endcase
      // the slot depends on the ring size: recompute after it changes
      if (cfg_we_i && cfg_idx_i == REG_SEG_COUNT) slot_ok_q <= 1'b0;
    end
  end

  // item payload and result fields
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          it_q        <= q_i.item;
          r_done_q    <= 1'b0;
          r_serial_q  <= '0;
          r_pos_q     <= '0;
          r_samples_q <= '0;
          r_start_q   <= '0;
          r_flags_q   <= '0;
          r_read_q    <= '0;
        end
      end
      S_DISPATCH: begin
        close_bytes_q <= fill_q;
        close_flags_q <= open_flags_q | 2'b10;
      end
      S_SLOT_WAIT: if (div_done) slot_q <= div_r[SLW-1:0];
      S_ADDR:  base_q <= base_prod[AW-1:0];
      S_WRITE: begin
        close_bytes_q <= fill_inc;
        close_flags_q <= open_flags_q;
      end
      S_CLOSE_WAIT: begin
        if (div_done) begin
          r_done_q    <= 1'b1;
          r_serial_q  <= completed_q;
          r_pos_q     <= open_pos_q;
          r_samples_q <= div_q[19:0];
          r_start_q   <= open_start_q;
          r_flags_q   <= close_flags_q;
        end
      end
      S_READ_WAIT: r_read_q <= ram_rdata;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      od_q <= {overrun_q, dropped_q, r_read_q, paused_q, r_flags_q, r_start_q,
               r_samples_q, r_pos_q, r_serial_q};
      ou_q <= r_done_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
endmodule
`default_nettype wire
